// ===== rtl/wire_strip_cut_sequencer_unit_defines.svh =====
`ifndef WIRE_STRIP_CUT_SEQUENCER_UNIT_DEFINES_SVH
`define WIRE_STRIP_CUT_SEQUENCER_UNIT_DEFINES_SVH

// Clocked assertion, off while reset is held.
`define WSC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also checks across reset.
`define WSC_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/wsc_pkg.sv =====
`timescale 1ns / 1ps
package wsc_pkg;

  localparam int STEP_COUNT_BITS_DEF = 20;
  localparam int CFG_W               = 20;
  localparam int CFG_IDX_W           = 3;
  localparam int CFG_STEP_W          = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_STEP_PERIOD    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIP_STEPS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAIN_STEPS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ISO_CUT_TICKS  = 3'd4;

  localparam logic [15:0]           STEP_PERIOD_RST    = 16'd40;
  localparam logic [CFG_STEP_W-1:0] STRIP_STEPS_RST    = 20'd13;
  localparam logic [CFG_STEP_W-1:0] MAIN_STEPS_RST     = 20'd154;
  localparam logic [7:0]            DEBOUNCE_LIMIT_RST = 8'd100;
  localparam logic [15:0]           ISO_CUT_TICKS_RST  = 16'd1510;

  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_LOOP = 1'b1;

  localparam logic DIR_RETRACT = 1'b0;
  localparam logic DIR_EXTRACT = 1'b1;

  typedef enum logic [2:0] {
    MOT_STOP        = 3'd0,
    MOT_CUT         = 3'd1,
    MOT_CUT_ISO     = 3'd2,
    MOT_CUTTING     = 3'd3,
    MOT_CUTTING_ISO = 3'd4,
    MOT_REVERSE     = 3'd5,
    MOT_CALIBRATE   = 3'd6,
    MOT_INIT        = 3'd7
  } mot_state_t;

  typedef enum logic [3:0] {
    SEQ_WAIT        = 4'd0,
    SEQ_START       = 4'd1,
    SEQ_EXT_FRONT   = 4'd2,
    SEQ_EXT_BACK    = 4'd3,
    SEQ_PREP_FRONT  = 4'd4,
    SEQ_PREP_BACK   = 4'd5,
    SEQ_RETRACT     = 4'd6,
    SEQ_RETRACT_FIN = 4'd7,
    SEQ_OPEN_CUTTER = 4'd8,
    SEQ_EXT_MAIN    = 4'd9,
    SEQ_CHOP        = 4'd10,
    SEQ_DONE        = 4'd11
  } seq_state_t;

  typedef enum logic [1:0] {
    DRV_OFF = 2'd0,
    DRV_FWD = 2'd1,
    DRV_REV = 2'd2
  } drive_t;

  typedef struct packed {
    logic action;
    logic down_button;
    logic up_button;
    logic cutter_home;
  } in_item_t;

  typedef struct packed {
    logic       step_level;
    logic       feed_direction;
    logic [1:0] cutter_drive;
    logic       stepper_enable;
    logic [2:0] motor_state;
    logic [3:0] sequence_state;
    logic       steps_pending;
  } out_item_t;

  typedef struct packed {
    logic [15:0]           step_period;
    logic [CFG_STEP_W-1:0] strip_steps;
    logic [CFG_STEP_W-1:0] main_steps;
    logic [7:0]            debounce_limit;
    logic [15:0]           iso_cut_ticks;
  } cfg_t;

endpackage

// ===== rtl/wsc_cfg_regs.sv =====
`timescale 1ns / 1ps
module wsc_cfg_regs
  import wsc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output cfg_t                 cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_STEP_PERIOD:    cfg_nxt.step_period    = cfg_wdata[15:0];
        CFG_STRIP_STEPS:    cfg_nxt.strip_steps    = cfg_wdata[CFG_STEP_W-1:0];
        CFG_MAIN_STEPS:     cfg_nxt.main_steps     = cfg_wdata[CFG_STEP_W-1:0];
        CFG_DEBOUNCE_LIMIT: cfg_nxt.debounce_limit = cfg_wdata[7:0];
        CFG_ISO_CUT_TICKS:  cfg_nxt.iso_cut_ticks  = cfg_wdata[15:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step_period    <= STEP_PERIOD_RST;
      cfg_r.strip_steps    <= STRIP_STEPS_RST;
      cfg_r.main_steps     <= MAIN_STEPS_RST;
      cfg_r.debounce_limit <= DEBOUNCE_LIMIT_RST;
      cfg_r.iso_cut_ticks  <= ISO_CUT_TICKS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/wsc_engine.sv =====
`timescale 1ns / 1ps
module wsc_engine
  import wsc_pkg::*;
#(
  parameter int STEP_COUNT_BITS = STEP_COUNT_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      go,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output out_item_t result_nxt
);

  localparam int SW = STEP_COUNT_BITS;

  logic [15:0] tick_count_r,   tick_count_nxt;
  logic [15:0] cutter_timer_r, cutter_timer_nxt;
  logic [SW-1:0] steps_left_r, steps_left_nxt;
  logic        direction_r,    direction_nxt;
  logic        step_pin_r,     step_pin_nxt;
  seq_state_t  seq_state_r,    seq_state_nxt;
  mot_state_t  mot_state_r,    mot_state_nxt;
  logic [7:0]  debounce_r,     debounce_nxt;
  drive_t      drive_r,        drive_nxt;
  logic        enable_r,       enable_nxt;
  logic [1:0]  last_buttons_r, last_buttons_nxt;

  logic [SW-1:0] strip_ld;
  logic [SW-1:0] main_ld;
  logic [15:0]   tick_inc;
  logic [7:0]    deb_sat;
  logic          down_rel;
  logic          up_rel;
  mot_state_t    mot_pre;
  mot_state_t    mot_seq;

  // step counts are cut or zero-extended to the counter width
  if (SW <= CFG_STEP_W) begin : g_ld_trunc
    assign strip_ld = cfg.strip_steps[SW-1:0];
    assign main_ld  = cfg.main_steps[SW-1:0];
  end else begin : g_ld_ext
    assign strip_ld = {{(SW-CFG_STEP_W){1'b0}}, cfg.strip_steps};
    assign main_ld  = {{(SW-CFG_STEP_W){1'b0}}, cfg.main_steps};
  end

  assign tick_inc = tick_count_r + 16'd1;
  assign deb_sat  = (debounce_r == 8'hFF) ? debounce_r : debounce_r + 8'd1;
  assign down_rel = last_buttons_r[0] && !item.down_button;
  assign up_rel   = last_buttons_r[1] && !item.up_button;

  // next state
  always_comb begin
    tick_count_nxt   = tick_count_r;
    cutter_timer_nxt = cutter_timer_r;
    steps_left_nxt   = steps_left_r;
    direction_nxt    = direction_r;
    step_pin_nxt     = step_pin_r;
    seq_state_nxt    = seq_state_r;
    mot_state_nxt    = mot_state_r;
    debounce_nxt     = debounce_r;
    drive_nxt        = drive_r;
    enable_nxt       = enable_r;
    last_buttons_nxt = last_buttons_r;
    mot_pre          = mot_state_r;
    mot_seq          = mot_state_r;

    if (go) begin
      if (item.action == ACT_TICK) begin
        tick_count_nxt = tick_inc;
        if (cutter_timer_r != 16'd0) cutter_timer_nxt = cutter_timer_r - 16'd1;
        if (tick_inc >= cfg.step_period) begin
          tick_count_nxt = 16'd0;
          if (steps_left_r != '0) begin
            step_pin_nxt   = !step_pin_r;
            steps_left_nxt = steps_left_r - SW'(1);
          end else begin
            step_pin_nxt = 1'b0;
          end
        end
      end else begin
        if (mot_state_r == MOT_INIT) mot_pre = item.cutter_home ? MOT_STOP : MOT_CALIBRATE;
        if (up_rel) mot_pre = MOT_CUT_ISO;
        mot_seq = mot_pre;

        // wire sequence
        case (seq_state_r)
          SEQ_WAIT: begin
            if (down_rel) begin
              enable_nxt     = 1'b1;
              steps_left_nxt = strip_ld;
              seq_state_nxt  = SEQ_EXT_FRONT;
            end
          end
          SEQ_EXT_FRONT: begin
            if (steps_left_r == '0) begin
              mot_seq       = MOT_CUT_ISO;
              seq_state_nxt = SEQ_RETRACT;
            end
          end
          SEQ_RETRACT: begin
            if (mot_pre == MOT_STOP) begin
              enable_nxt     = 1'b1;
              direction_nxt  = DIR_RETRACT;
              steps_left_nxt = strip_ld;
              seq_state_nxt  = SEQ_RETRACT_FIN;
            end
          end
          SEQ_RETRACT_FIN: begin
            if (steps_left_r == '0) begin
              mot_seq       = MOT_REVERSE;
              direction_nxt = DIR_EXTRACT;
              seq_state_nxt = SEQ_PREP_FRONT;
            end
          end
          SEQ_PREP_FRONT: begin
            if (mot_pre == MOT_STOP) begin
              enable_nxt     = 1'b1;
              steps_left_nxt = main_ld;
              seq_state_nxt  = SEQ_EXT_MAIN;
            end
          end
          SEQ_EXT_MAIN: begin
            if (steps_left_r == '0) begin
              mot_seq       = MOT_CUT_ISO;
              seq_state_nxt = SEQ_PREP_BACK;
            end
          end
          SEQ_PREP_BACK: begin
            if (mot_pre == MOT_STOP) begin
              steps_left_nxt = strip_ld;
              seq_state_nxt  = SEQ_EXT_BACK;
            end
          end
          SEQ_EXT_BACK: begin
            if (steps_left_r == '0) begin
              mot_seq       = MOT_CUT;
              seq_state_nxt = SEQ_CHOP;
            end
          end
          SEQ_CHOP: begin
            if (mot_pre == MOT_STOP) seq_state_nxt = SEQ_DONE;
          end
          SEQ_DONE: begin
            seq_state_nxt = SEQ_WAIT;
            enable_nxt    = 1'b0;
          end
          default: seq_state_nxt = seq_state_r;
        endcase

        // cutter motor
        mot_state_nxt = mot_seq;
        case (mot_seq)
          MOT_STOP: drive_nxt = DRV_OFF;
          MOT_CUT, MOT_CUT_ISO: begin
            drive_nxt    = DRV_FWD;
            debounce_nxt = item.cutter_home ? 8'd0 : deb_sat;
            if (debounce_nxt < cfg.debounce_limit) begin
              if (mot_seq == MOT_CUT_ISO) cutter_timer_nxt = cfg.iso_cut_ticks;
            end else begin
              mot_state_nxt = (mot_seq == MOT_CUT) ? MOT_CUTTING : MOT_CUTTING_ISO;
            end
          end
          MOT_CUTTING_ISO: begin
            if (cutter_timer_r == 16'd0) begin
              drive_nxt     = DRV_REV;
              mot_state_nxt = MOT_REVERSE;
            end
          end
          MOT_REVERSE: begin
            drive_nxt     = DRV_REV;
            mot_state_nxt = MOT_CUTTING;
          end
          MOT_CALIBRATE: mot_state_nxt = MOT_CUT;
          MOT_CUTTING: begin
            debounce_nxt = item.cutter_home ? deb_sat : 8'd0;
            if (debounce_nxt > cfg.debounce_limit) begin
              drive_nxt     = DRV_OFF;
              mot_state_nxt = MOT_STOP;
            end
          end
          default: mot_state_nxt = mot_seq;
        endcase

        last_buttons_nxt = {item.up_button, item.down_button};
      end
    end
  end

  // result fields
  always_comb begin
    result_nxt.step_level     = step_pin_nxt;
    result_nxt.feed_direction = direction_nxt;
    result_nxt.cutter_drive   = drive_nxt;
    result_nxt.stepper_enable = enable_nxt;
    result_nxt.motor_state    = mot_state_nxt;
    result_nxt.sequence_state = seq_state_nxt;
    result_nxt.steps_pending  = |steps_left_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_count_r   <= 16'd0;
      cutter_timer_r <= 16'd0;
      steps_left_r   <= '0;
      direction_r    <= DIR_EXTRACT;
      step_pin_r     <= 1'b0;
      seq_state_r    <= SEQ_WAIT;
      mot_state_r    <= MOT_INIT;
      debounce_r     <= 8'd0;
      drive_r        <= DRV_OFF;
      enable_r       <= 1'b0;
      last_buttons_r <= 2'b00;
    end else begin
      tick_count_r   <= tick_count_nxt;
      cutter_timer_r <= cutter_timer_nxt;
      steps_left_r   <= steps_left_nxt;
      direction_r    <= direction_nxt;
      step_pin_r     <= step_pin_nxt;
      seq_state_r    <= seq_state_nxt;
      mot_state_r    <= mot_state_nxt;
      debounce_r     <= debounce_nxt;
      drive_r        <= drive_nxt;
      enable_r       <= enable_nxt;
      last_buttons_r <= last_buttons_nxt;
    end
  end

endmodule

// ===== rtl/wire_strip_cut_sequencer_unit.sv =====
`timescale 1ns / 1ps
// Wire strip-and-cut sequencer: drives a stepper wire feeder and a cutter motor.
// Input channel in_valid/in_stall/in_item: each item is a timer tick
// (action 0) or a control-loop step (action 1) carrying the button and
// cutter home switch samples. Every item yields exactly one result item on
// out_valid/out_stall/out_item with the step pin, direction, cutter drive,
// stepper enable, motor and sequence states, and a steps-pending flag.
// Each item passes the input register, then the result register, before its
// result shows on out_item.
// Throughput: one item per cycle while out_stall is low; the combinational
// state update between the input and result registers sets that rate.
// A stalled result is held in the result register while the next item waits
// in the input register; in_stall rises only when both are full.
// cfg_we/cfg_index/cfg_wdata write the configuration registers; write them
// only while the block is idle.
// Reset (rst_n low, synchronous) empties both registers, loads the default
// configuration and puts the motor machine in init, which picks stop or
// calibrate from the first home switch sample.
module wire_strip_cut_sequencer_unit
  import wsc_pkg::*;
#(
  parameter int STEP_COUNT_BITS = STEP_COUNT_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  cfg_t      cfg;
  out_item_t result_nxt;

  logic      in_valid_r, in_valid_nxt;
  in_item_t  in_item_r;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r;
  logic      advance;
  logic      in_take;

  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_take)      in_valid_nxt = 1'b1;
    else if (advance) in_valid_nxt = 1'b0;

    out_valid_nxt = out_valid_r && out_stall;
    if (advance) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) in_item_r <= in_item;
    if (advance) out_item_r <= result_nxt;
  end

  wsc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  wsc_engine #(
    .STEP_COUNT_BITS (STEP_COUNT_BITS)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .go         (advance),
    .item       (in_item_r),
    .cfg        (cfg),
    .result_nxt (result_nxt)
  );

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== rtl/wsc_checker.sv =====
`timescale 1ns / 1ps
`include "wire_strip_cut_sequencer_unit_defines.svh"
module wsc_checker
  import wsc_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  // nothing comes out right after reset
  `WSC_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid, "result valid after reset")

  `WSC_ASSERT(a_stall_hold, out_valid && out_stall |=> out_valid && $stable(out_item), "stalled item changed")

  // idle sequence never leaves the stepper driver on
  `WSC_ASSERT(a_wait_disabled, out_valid && out_item.sequence_state == SEQ_WAIT |-> !out_item.stepper_enable, "stepper enabled in wait")

  // stopped motor means the cutter is not driven
  `WSC_ASSERT(a_stop_off, out_valid && out_item.motor_state == MOT_STOP |-> out_item.cutter_drive == DRV_OFF, "cutter driven while stopped")

endmodule

bind wire_strip_cut_sequencer_unit wsc_checker u_wsc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
